@@ sv/ndd_pkg.sv @@
// shared constants, types and helpers of the divided-difference interpolator
package ndd_pkg;

  localparam int MaxNodes = 8;
  localparam int IdxW     = $clog2(MaxNodes);
  localparam int CntW     = $clog2(MaxNodes + 1);
  localparam int XW       = 16;
  localparam int SW       = 32;
  localparam int FracW    = 12;
  localparam int DenW     = XW + 1;
  localparam int NumW     = SW + 1 + FracW;
  localparam int DivCw    = $clog2(NumW + 1);
  localparam int MulW     = 32;
  localparam int MulCw    = $clog2(MulW + 1);

  localparam logic OP_LOAD = 1'b0;
  localparam logic OP_EVAL = 1'b1;

  localparam logic [1:0] ST_OK  = 2'd0;
  localparam logic [1:0] ST_REP = 2'd1;
  localparam logic [1:0] ST_SAT = 2'd2;

  typedef enum logic [3:0] {
    S_IDLE, S_CHK_RD, S_CHK_CMP, S_CP_RD, S_CP_WR, S_DD_RD, S_DD_GO, S_DD_WAIT,
    S_F_RD, S_F_GO, S_F_WAIT, S_T_RD, S_T_GO, S_T_WAIT, S_FIN
  } state_e;

  typedef struct packed {
    logic [SW-1:0] v;
    logic          s;
  } sat_t;

  // signed value given as magnitude and sign, clamped to 32 bits
  function automatic sat_t clamp_mag(input logic [63:0] mag, input logic neg);
    sat_t r;
    r.s = 1'b0;
    if (neg) begin
      if (mag > 64'h0000_0000_8000_0000) begin
        r.v = 32'h8000_0000;
        r.s = 1'b1;
      end else begin
        r.v = ~mag[31:0] + 32'd1;
      end
    end else begin
      if (mag > 64'h0000_0000_7fff_ffff) begin
        r.v = 32'h7fff_ffff;
        r.s = 1'b1;
      end else begin
        r.v = mag[31:0];
      end
    end
    return r;
  endfunction

  function automatic sat_t clamp_s64(input logic signed [63:0] v);
    sat_t r;
    r.s = 1'b0;
    if (v > 64'sh0000_0000_7fff_ffff) begin
      r.v = 32'h7fff_ffff;
      r.s = 1'b1;
    end else if (v < -64'sh0000_0000_8000_0000) begin
      r.v = 32'h8000_0000;
      r.s = 1'b1;
    end else begin
      r.v = v[31:0];
    end
    return r;
  endfunction

endpackage

@@ sv/ndd_div.sv @@
// bit-serial restoring divider, one quotient bit per cycle, unsigned
module ndd_div import ndd_pkg::*; (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            start_i,
  input  logic [NumW-1:0] dividend_i,
  input  logic [DenW-1:0] divisor_i,
  output logic            done_o,
  output logic [NumW-1:0] quot_o
);

  logic             busy_q, done_q;
  logic [DivCw-1:0] cnt_q;
  logic [NumW-1:0]  dvd_q;
  logic [DenW-1:0]  rem_q, den_q;
  logic [DenW:0]    rem_sh;
  logic             ge;

  assign rem_sh = {rem_q, dvd_q[NumW-1]};
  assign ge     = rem_sh >= {1'b0, den_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i && !busy_q) begin
        busy_q <= 1'b1;
        cnt_q  <= DivCw'(NumW);
      end else if (busy_q) begin
        cnt_q <= cnt_q - 1'b1;
        if (cnt_q == DivCw'(1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i && !busy_q) begin
      dvd_q <= dividend_i;
      den_q <= divisor_i;
      rem_q <= '0;
    end else if (busy_q) begin
      rem_q <= ge ? DenW'(rem_sh - {1'b0, den_q}) : rem_sh[DenW-1:0];
      dvd_q <= {dvd_q[NumW-2:0], ge};
    end
  end

  assign done_o = done_q;
  assign quot_o = dvd_q;

endmodule

@@ sv/ndd_mul.sv @@
// bit-serial shift-add multiplier, one multiplier bit per cycle, unsigned
module ndd_mul import ndd_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start_i,
  input  logic [MulW-1:0]   a_i,
  input  logic [MulW-1:0]   b_i,
  output logic              done_o,
  output logic [2*MulW-1:0] prod_o
);

  logic             busy_q, done_q;
  logic [MulCw-1:0] cnt_q;
  logic [MulW-1:0]  a_q;
  logic [2*MulW-1:0] p_q;
  logic [MulW:0]    sum;

  assign sum = {1'b0, p_q[2*MulW-1:MulW]} + (p_q[0] ? {1'b0, a_q} : '0);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i && !busy_q) begin
        busy_q <= 1'b1;
        cnt_q  <= MulCw'(MulW);
      end else if (busy_q) begin
        cnt_q <= cnt_q - 1'b1;
        if (cnt_q == MulCw'(1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i && !busy_q) begin
      a_q <= a_i;
      p_q <= {{MulW{1'b0}}, b_i};
    end else if (busy_q) begin
      p_q <= {sum, p_q[MulW-1:1]};
    end
  end

  assign done_o = done_q;
  assign prod_o = p_q;

endmodule

@@ sv/newton_divided_difference_interp.sv @@
// top level: node store, divided-difference sequencer and evaluation
//
// channel   dir  width  contents
// s_axis    in   56+1   tdata: node_index, x_value, sample_value; tuser: operation
// m_axis    out  40     tdata: value, status
// cfg       in   4      num_nodes, written when cfg_we_i is high
//
// a load request is written in the idle state and leaves the core idle; an evaluate
// request checks the node pairs for repeats, then runs n(n-1)/2 divided differences
// on the bit-serial divider (45 quotient bits) and 2(n-1) products on the bit-serial
// multiplier (32 bits) for n nodes
// reset clears the sequencer and the result valid flag and sets num_nodes to 4;
// node memories hold garbage until loaded
// a finished result waits in the output register; a new request is taken
// while it waits, and the next result waits until the old one is taken
module newton_divided_difference_interp import ndd_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [3:0]  cfg_wdata_i,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [55:0] s_axis_tdata,   // node_index, x_value, sample_value, zero pad
  input  logic        s_axis_tuser,   // operation
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [39:0] m_axis_tdata    // value, status, zero pad
);

  // request fields
  logic [IdxW-1:0] in_idx;
  logic [XW-1:0]   in_x;
  logic [SW-1:0]   in_s;
  assign in_idx = s_axis_tdata[IdxW-1:0];
  assign in_x   = s_axis_tdata[IdxW+XW-1:IdxW];
  assign in_s   = s_axis_tdata[IdxW+XW+SW-1:IdxW+XW];

  state_e state_q, state_d;
  logic   in_acc;
  assign in_acc = s_axis_tvalid && s_axis_tready;

  // configuration
  logic [3:0]      num_nodes_q;
  logic [CntW-1:0] n_eff, n_q;
  always_comb begin
    if (num_nodes_q == 4'd0) begin
      n_eff = CntW'(1);
    end else if ({1'b0, num_nodes_q} > 5'(MaxNodes)) begin
      n_eff = CntW'(MaxNodes);
    end else begin
      n_eff = CntW'(num_nodes_q);
    end
  end

  // node store and working column
  logic [XW-1:0] xmem [MaxNodes];
  logic [SW-1:0] smem [MaxNodes];
  logic [SW-1:0] dmem [MaxNodes];
  logic [IdxW-1:0] ra, rb, rx;
  logic [XW-1:0] xa_q, xb_q;
  logic [SW-1:0] sa_q, da_q, db_q;
  logic          dwe;
  sat_t          dd_res;

  // sequencer registers; ci/cj are pair counters in the check and i/j later
  logic [CntW-1:0]  ci_q, cj_q;
  logic [XW-1:0]    q_q;
  logic [SW-1:0]    f_q;
  logic [63:0]      acc_q;
  logic             sat_q, rep_q, neg_q;
  logic             out_valid_q;
  logic [SW-1:0]    value_q;
  logic [1:0]       status_q;

  // serial units
  logic            div_start, div_done;
  logic [NumW-1:0] div_dvd, div_quot;
  logic [DenW-1:0] div_den;
  logic            mul_start, mul_done;
  logic [MulW-1:0] mul_a, mul_b;
  logic [2*MulW-1:0] mul_prod;

  // operand preparation
  logic [SW:0]     ddiff, dmag;
  logic [DenW-1:0] xdiff, xmag;
  logic [DenW-1:0] qdiff, qmag;
  logic [SW-1:0]   fmag, cmag;
  logic            dd_neg, f_neg, t_neg;
  logic [63:0]     pmag, term;
  sat_t            f_res, acc_res;
  logic            fin_go;

  assign ddiff = {da_q[SW-1], da_q} - {db_q[SW-1], db_q};
  assign dmag  = ddiff[SW] ? (~ddiff + 1'b1) : ddiff;
  assign xdiff = {xa_q[XW-1], xa_q} - {xb_q[XW-1], xb_q};
  assign xmag  = xdiff[DenW-1] ? (~xdiff + 1'b1) : xdiff;
  assign dd_neg = ddiff[SW] ^ xdiff[DenW-1];
  assign div_dvd = {dmag, {FracW{1'b0}}};
  assign div_den = xmag;

  assign qdiff = {q_q[XW-1], q_q} - {xa_q[XW-1], xa_q};
  assign qmag  = qdiff[DenW-1] ? (~qdiff + 1'b1) : qdiff;
  assign fmag  = f_q[SW-1] ? (~f_q + 1'b1) : f_q;
  assign cmag  = da_q[SW-1] ? (~da_q + 1'b1) : da_q;
  assign f_neg = f_q[SW-1] ^ qdiff[DenW-1];
  assign t_neg = f_q[SW-1] ^ da_q[SW-1];

  assign mul_a = fmag;
  assign mul_b = (state_q == S_F_GO) ? MulW'(qmag) : cmag;

  assign dd_res  = clamp_mag(64'(div_quot), neg_q);
  assign pmag    = {{FracW{1'b0}}, mul_prod[2*MulW-1:FracW]};
  assign f_res   = clamp_mag(pmag, neg_q);
  assign term    = neg_q ? (~pmag + 64'd1) : pmag;
  assign acc_res = clamp_s64(acc_q);
  assign fin_go  = !out_valid_q || m_axis_tready;

  ndd_div u_div (
    .clk_i, .rst_ni,
    .start_i   (div_start),
    .dividend_i(div_dvd),
    .divisor_i (div_den),
    .done_o    (div_done),
    .quot_o    (div_quot)
  );

  ndd_mul u_mul (
    .clk_i, .rst_ni,
    .start_i(mul_start),
    .a_i    (mul_a),
    .b_i    (mul_b),
    .done_o (mul_done),
    .prod_o (mul_prod)
  );

  // next state, read addresses and unit strobes
  always_comb begin
    state_d   = state_q;
    ra        = ci_q[IdxW-1:0];
    rb        = IdxW'(ci_q + 1'b1);
    rx        = IdxW'(ci_q + cj_q);
    div_start = 1'b0;
    mul_start = 1'b0;
    dwe       = 1'b0;
    s_axis_tready = (state_q == S_IDLE);
    case (state_q)
      S_IDLE: begin
        if (in_acc && s_axis_tuser == OP_EVAL) begin
          state_d = (n_eff == CntW'(1)) ? S_CP_RD : S_CHK_RD;
        end
      end
      S_CHK_RD: begin
        rx = cj_q[IdxW-1:0];
        state_d = S_CHK_CMP;
      end
      S_CHK_CMP: begin
        if (xa_q == xb_q) begin
          state_d = S_FIN;
        end else if (cj_q + 1'b1 < n_q || CntW'(ci_q + 2'd2) < n_q) begin
          state_d = S_CHK_RD;
        end else begin
          state_d = S_CP_RD;
        end
      end
      S_CP_RD: state_d = S_CP_WR;
      S_CP_WR: begin
        if (ci_q + 1'b1 < n_q) begin
          state_d = S_CP_RD;
        end else begin
          state_d = (n_q > CntW'(1)) ? S_DD_RD : S_FIN;
        end
      end
      S_DD_RD: state_d = S_DD_GO;
      S_DD_GO: begin
        div_start = 1'b1;
        state_d   = S_DD_WAIT;
      end
      S_DD_WAIT: begin
        if (div_done) begin
          dwe = 1'b1;
          state_d = (ci_q + 1'b1 < n_q - cj_q) ? S_DD_RD : S_F_RD;
        end
      end
      S_F_RD: begin
        ra = IdxW'(cj_q - 1'b1);
        state_d = S_F_GO;
      end
      S_F_GO: begin
        mul_start = 1'b1;
        state_d   = S_F_WAIT;
      end
      S_F_WAIT: if (mul_done) state_d = S_T_RD;
      S_T_RD: begin
        ra = '0;
        state_d = S_T_GO;
      end
      S_T_GO: begin
        mul_start = 1'b1;
        state_d   = S_T_WAIT;
      end
      S_T_WAIT: begin
        if (mul_done) begin
          state_d = (cj_q + 1'b1 < n_q) ? S_DD_RD : S_FIN;
        end
      end
      S_FIN: if (fin_go) state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      num_nodes_q <= 4'd4;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (cfg_we_i) num_nodes_q <= cfg_wdata_i;
      if (state_q == S_FIN && fin_go) begin
        out_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // memories: one write per array per cycle, registered reads
  always_ff @(posedge clk_i) begin
    xa_q <= xmem[ra];
    xb_q <= xmem[rx];
    sa_q <= smem[ra];
    da_q <= dmem[ra];
    db_q <= dmem[rb];
    if (in_acc && s_axis_tuser == OP_LOAD) begin
      xmem[in_idx] <= in_x;
      smem[in_idx] <= in_s;
    end
    if (state_q == S_CP_WR) begin
      dmem[ci_q[IdxW-1:0]] <= sa_q;
    end else if (dwe) begin
      dmem[ci_q[IdxW-1:0]] <= dd_res.v;
    end
  end

  // datapath
  always_ff @(posedge clk_i) begin
    case (state_q)
      S_IDLE: begin
        n_q   <= n_eff;
        q_q   <= in_x;
        ci_q  <= '0;
        cj_q  <= CntW'(1);
        sat_q <= 1'b0;
        rep_q <= 1'b0;
        f_q   <= SW'(1 << FracW);
      end
      S_CHK_CMP: begin
        if (xa_q == xb_q) begin
          rep_q <= 1'b1;
        end else if (cj_q + 1'b1 < n_q) begin
          cj_q <= cj_q + 1'b1;
        end else if (CntW'(ci_q + 2'd2) < n_q) begin
          ci_q <= ci_q + 1'b1;
          cj_q <= CntW'(ci_q + 2'd2);
        end else begin
          ci_q <= '0;
        end
      end
      S_CP_WR: begin
        if (ci_q == '0) acc_q <= {{(64-SW){sa_q[SW-1]}}, sa_q};
        if (ci_q + 1'b1 < n_q) begin
          ci_q <= ci_q + 1'b1;
        end else begin
          ci_q <= '0;
          cj_q <= CntW'(1);
        end
      end
      S_DD_GO: neg_q <= dd_neg;
      S_DD_WAIT: begin
        if (div_done) begin
          sat_q <= sat_q | dd_res.s;
          ci_q  <= ci_q + 1'b1;
        end
      end
      S_F_GO: neg_q <= f_neg;
      S_F_WAIT: begin
        if (mul_done) begin
          f_q   <= f_res.v;
          sat_q <= sat_q | f_res.s;
        end
      end
      S_T_GO: neg_q <= t_neg;
      S_T_WAIT: begin
        if (mul_done) begin
          acc_q <= acc_q + term;
          ci_q  <= '0;
          cj_q  <= cj_q + 1'b1;
        end
      end
      S_FIN: begin
        if (fin_go) begin
          value_q  <= rep_q ? '0 : acc_res.v;
          status_q <= rep_q ? ST_REP : ((sat_q || acc_res.s) ? ST_SAT : ST_OK);
        end
      end
      default: ;
    endcase
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {6'd0, status_q, value_q};

  // checks
  a_status_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> m_axis_tdata[33:32] != 2'd3)
    else $error("illegal status code");
  a_rep_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && m_axis_tdata[33:32] == ST_REP) |-> m_axis_tdata[31:0] == 32'd0)
    else $error("repeated node result not zero");
  a_load_quick: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_acc && s_axis_tuser == OP_LOAD) |=> state_q == S_IDLE)
    else $error("load left the idle state");
  a_n_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q != S_IDLE) |-> (n_q != '0 && n_q <= CntW'(MaxNodes)))
    else $error("node count out of range");

endmodule

@@ dv/testbench.sv @@
// self-checking testbench for the newton divided-difference interpolator
`timescale 1ns / 100ps

module testbench;
  import ndd_pkg::*;

  // a run ends with a failure after this many cycles
  localparam int CycleLimit = 3_000_000;
  // the core's settle time after the last result, generous vs a load request
  localparam int SettleCycles = 20;

  logic        clk_i = 1'b0;
  logic        rst_ni;
  logic        cfg_we_i;
  logic [3:0]  cfg_wdata_i;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  logic [55:0] s_axis_tdata;   // node_index, x_value, sample_value, zero pad
  logic        s_axis_tuser;   // operation
  logic        m_axis_tvalid;
  logic        m_axis_tready;
  logic [39:0] m_axis_tdata;   // value, status, zero pad

  typedef struct packed {
    logic [SW-1:0] value;
    logic [1:0]    status;
  } interp_result_t;

  // shadow of the core: node store and node count
  shortint        node_x [MaxNodes];
  int             node_s [MaxNodes];
  logic [3:0]     num_nodes_shadow;
  interp_result_t interp_queue [$];

  int  mismatches = 0;
  int  cycles = 0;
  bit  no_idle = 1'b0;
  int  ready_hold = 0;

  newton_divided_difference_interp i_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  // 10 ns clock
  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // watchdog
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CycleLimit) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  // clamp to signed 32 bits, flagging any change
  function automatic longint clip32(input longint v, inout bit sat);
    if (v > 64'sd2147483647) begin
      sat = 1'b1;
      return 64'sd2147483647;
    end
    if (v < -64'sd2147483648) begin
      sat = 1'b1;
      return -64'sd2147483648;
    end
    return v;
  endfunction

  // interpolated value at query point q over the shadow nodes
  function automatic interp_result_t interpolate(input shortint q);
    interp_result_t r;
    int     n;
    int     coef [MaxNodes];
    longint f, acc, num, den;
    bit     sat;
    sat = 1'b0;
    n = int'(num_nodes_shadow);
    if (n < 1) n = 1;
    if (n > MaxNodes) n = MaxNodes;
    // repeated abscissa wins over everything else
    for (int i = 0; i < n; i++)
      for (int j = i + 1; j < n; j++)
        if (node_x[i] == node_x[j]) begin
          r.value = '0;
          r.status = ST_REP;
          return r;
        end
    for (int i = 0; i < n; i++) coef[i] = node_s[i];
    f = 4096;
    acc = longint'(coef[0]) * f / 4096;
    for (int j = 1; j < n; j++) begin
      for (int i = 0; i < n - j; i++) begin
        num = longint'(coef[i]) - longint'(coef[i + 1]);
        den = longint'(node_x[i]) - longint'(node_x[i + j]);
        coef[i] = int'(clip32(num * 4096 / den, sat));
      end
      f = clip32(f * (longint'(q) - longint'(node_x[j - 1])) / 4096, sat);
      acc += longint'(coef[0]) * f / 4096;
    end
    acc = clip32(acc, sat);
    r.value = acc[31:0];
    r.status = sat ? ST_SAT : ST_OK;
    return r;
  endfunction

  function automatic int pick_gap();
    if (no_idle) return 0;
    if ($urandom_range(0, 9) < 8) return $urandom_range(0, 2);
    return $urandom_range(3, 40);
  endfunction

  // result side: random stalls, mostly short
  always @(posedge clk_i) begin
    if (!rst_ni || no_idle) begin
      m_axis_tready <= 1'b1;
    end else if (ready_hold > 0) begin
      ready_hold <= ready_hold - 1;
      m_axis_tready <= 1'b0;
    end else if ($urandom_range(0, 3) == 0) begin
      ready_hold <= ($urandom_range(0, 9) < 8) ? $urandom_range(0, 3) : $urandom_range(4, 60);
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= 1'b1;
    end
  end

  task automatic report_mismatch(input string what, input logic [31:0] want,
                                 input logic [31:0] got);
    $display("mismatch %s: expected %h got %h at %0t", what, want, got, $realtime);
    mismatches++;
  endtask

  // result checker: oldest expectation first
  always @(posedge clk_i) begin
    interp_result_t want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (interp_queue.size() == 0) begin
        report_mismatch("unexpected result", '0, m_axis_tdata[31:0]);
      end else begin
        want = interp_queue.pop_front();
        if (m_axis_tdata[31:0] !== want.value)
          report_mismatch("value", want.value, m_axis_tdata[31:0]);
        if (m_axis_tdata[33:32] !== want.status)
          report_mismatch("status", 32'(want.status), 32'(m_axis_tdata[33:32]));
      end
    end
  end

  // one request, waits for acceptance, then updates the shadow nodes or records the prediction
  task automatic send_request(input logic op, input logic [2:0] idx,
                              input logic [15:0] xv, input logic [31:0] sv);
    int gap;
    s_axis_tuser  <= op;
    s_axis_tdata  <= {5'd0, sv, xv, idx};
    s_axis_tvalid <= 1'b1;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    if (op == OP_LOAD) begin
      node_x[idx] = shortint'(xv);
      node_s[idx] = int'(sv);
    end else begin
      interp_queue.push_back(interpolate(shortint'(xv)));
    end
    gap = pick_gap();
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
  endtask

  task automatic load_node(input logic [2:0] idx, input logic [15:0] xv,
                           input logic [31:0] sv);
    send_request(OP_LOAD, idx, xv, sv);
  endtask

  task automatic evaluate_at(input logic [15:0] q);
    send_request(OP_EVAL, 3'($urandom_range(0, 7)), q, $urandom);
  endtask

  // node count is written only once the core is idle
  task automatic set_num_nodes(input logic [3:0] n);
    s_axis_tvalid <= 1'b0;
    while (interp_queue.size() > 0) @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= n;
    @(posedge clk_i);
    num_nodes_shadow = n;
    cfg_we_i <= 1'b0;
  endtask

  // evenly spread distinct nodes with moderate samples
  task automatic load_spread_nodes(input int count);
    int base, step;
    base = $urandom_range(0, 16000) - 8000;
    step = $urandom_range(64, 2048);
    if ($urandom_range(0, 1)) step = -step;
    for (int k = 0; k < count; k++)
      load_node(k[2:0], 16'(base + k * step), 32'($urandom_range(0, 2 ** 21) - 2 ** 20));
  endtask

  // default node count after reset, all slots loaded first
  task automatic test_reset_default();
    no_idle = 1'b1;
    for (int k = 0; k < MaxNodes; k++)
      load_node(k[2:0], 16'(k * 4096 - 16384), 32'(k * k * 65536));
    evaluate_at(16'sd0);
    evaluate_at(16'sd2048);
    no_idle = 1'b0;
  endtask

  // field extremes and saturation
  task automatic test_extremes();
    set_num_nodes(4'd2);
    load_node(3'd0, 16'h8000, 32'h8000_0000);
    load_node(3'd1, 16'h7fff, 32'h7fff_ffff);
    evaluate_at(16'h8000);
    evaluate_at(16'h7fff);
    evaluate_at(16'h0000);
    set_num_nodes(4'd3);
    load_node(3'd1, 16'h0001, 32'h7fff_ffff);
    load_node(3'd2, 16'h0000, 32'h8000_0000);
    evaluate_at(16'h7fff);
    evaluate_at(16'hffff);
  endtask

  // equal abscissae among the used nodes, then only beyond the node count
  task automatic test_repeated_node();
    set_num_nodes(4'd5);
    load_spread_nodes(5);
    load_node(3'd4, 16'(node_x[1]), 32'h0001_0000);
    evaluate_at(16'h1000);
    set_num_nodes(4'd4);
    evaluate_at(16'h1000);
  endtask

  // zero is used as one node, values above the maximum as the maximum
  task automatic test_node_counts();
    load_spread_nodes(MaxNodes);
    set_num_nodes(4'd0);
    evaluate_at(16'h0123);
    set_num_nodes(4'd1);
    evaluate_at(16'hfedc);
    set_num_nodes(4'd8);
    evaluate_at(16'h0800);
    set_num_nodes(4'd15);
    evaluate_at(16'hf800);
    set_num_nodes(4'd9);
    evaluate_at(16'h0400);
  endtask

  // rounds of node sets with random content, plus noise
  task automatic test_random(input int budget);
    int sent, n, evals;
    logic [3:0] cfg;
    sent = 0;
    while (sent < budget) begin
      no_idle = ($urandom_range(0, 7) == 0);
      n = ($urandom_range(0, 3) == 0) ? $urandom_range(5, 8) : $urandom_range(1, 4);
      cfg = 4'(n);
      if ($urandom_range(0, 9) == 0) cfg = (n == 1) ? 4'd0 : 4'(n + 7);
      if (cfg > 4'd8) n = MaxNodes;
      set_num_nodes(cfg);
      if ($urandom_range(0, 9) == 0) begin
        // full-range noise nodes
        for (int k = 0; k < n; k++) load_node(k[2:0], 16'($urandom), $urandom);
      end else begin
        load_spread_nodes(n);
      end
      sent += n;
      if ($urandom_range(0, 7) == 0 && n > 1)
        load_node(3'($urandom_range(1, n - 1)), 16'(node_x[0]), $urandom);
      if ($urandom_range(0, 3) == 0 && n < MaxNodes) begin
        load_node(3'($urandom_range(n, MaxNodes - 1)), 16'($urandom), $urandom);
        sent++;
      end
      evals = $urandom_range(2, 6);
      for (int e = 0; e < evals; e++) begin
        if ($urandom_range(0, 4) == 0) evaluate_at(16'($urandom));
        else evaluate_at(16'(int'(node_x[$urandom_range(0, n - 1)]) +
                            $urandom_range(0, 4096) - 2048));
      end
      sent += evals;
    end
    no_idle = 1'b0;
  endtask

  initial begin
    rst_ni        = 1'b0;
    cfg_we_i      = 1'b0;
    cfg_wdata_i   = 4'd0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    s_axis_tuser  = OP_LOAD;
    num_nodes_shadow = 4'd4;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_reset_default();
    test_extremes();
    test_repeated_node();
    test_node_counts();
    test_random(470);

    // drain and let the core settle
    s_axis_tvalid <= 1'b0;
    while (interp_queue.size() > 0) @(posedge clk_i);
    repeat (50) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

@@ sim.f @@
sv/ndd_pkg.sv
sv/ndd_div.sv
sv/ndd_mul.sv
sv/newton_divided_difference_interp.sv
dv/testbench.sv
